FILE: rtl/hsm_pkg.sv
// Shared types and constants for the heightfield shadow march block.
`default_nettype none
package hsm_pkg;
  localparam int MAX_DIM    = 255;
  localparam int COORD_W    = 8;                 // bits of one in-store coordinate
  localparam int STORE_AW   = 2 * COORD_W;
  localparam int HEIGHT_W   = 24;
  localparam int LIMIT_W    = 14;
  localparam int LIMIT_NUM  = 204800;            // 800 m in Q10.8 cell units
  localparam int LIMIT_RST  = 800;
  localparam int DIV_W      = 18;                // bits of LIMIT_NUM
  localparam int CELL_MIN   = 16;
  localparam int START_BIAS = 51;                // 0.2 m in Q15.8
  localparam int CLIMB_LIM  = 100 * 8388608;     // 100 m in 2^-23 m
  localparam int MUL_AW     = 25;
  localparam int MUL_BW     = 18;
  localparam int MUL_PW     = MUL_AW + MUL_BW;
  localparam int ACC_W      = 60;

  typedef enum logic [2:0] {
    REG_SUN_X    = 3'd0,
    REG_SUN_Y    = 3'd1,
    REG_SUN_Z    = 3'd2,
    REG_CELL     = 3'd3,
    REG_MAP_DIM  = 3'd4
  } cfg_reg_t;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHK,
    ST_H0,
    ST_ADV,
    ST_ADDR,
    ST_CA,
    ST_CB,
    ST_CC,
    ST_CD,
    ST_CMP
  } hsm_state_t;

  typedef struct packed {
    logic                          we;
    logic [STORE_AW-1:0]           addr;
    logic signed [HEIGHT_W-1:0]    wdata;
  } store_req_t;
endpackage
`default_nettype wire

FILE: rtl/heightfield_shadow_march.sv
// Top level: height store writes and shadow ray march under a small sequencer.
// Write: no result. Query: low sun or off-map cell strobes from the check state, else
// march steps (advance, corner reads on the map, compare) run until a result or the
// step limit; busy drops with the strobe unless a divide runs. A cell spacing write
// holds busy high and cfg_ready low for the limit divide. Synchronous active-low
// reset restores register defaults, not the height store; results cannot be stalled.
`default_nettype none
module heightfield_shadow_march
  import hsm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic                     in_cmd,
  input  wire logic signed [9:0]        in_grid_x,
  input  wire logic signed [9:0]        in_grid_z,
  input  wire logic signed [23:0]       in_height,
  output logic                          out_valid,
  output logic                          out_shadowed,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [2:0]               cfg_index,
  input  wire logic [15:0]              cfg_wdata
);
  hsm_state_t state_r, state_nxt;

  logic signed [15:0] sun_x_r, sun_y_r, sun_z_r;
  logic [15:0]        cell_r;
  logic [7:0]         dim_r, dim_eff;
  logic               cfg_we, div_busy;
  logic [LIMIT_W-1:0] limit;

  logic signed [9:0]          gx_r, gz_r;
  logic signed [HEIGHT_W-1:0] h0_r, h_r, rd_data;
  logic [31:0]                dy_r;
  logic [32:0]                rise_r;
  logic signed [31:0]         fx_r, fz_r;
  logic [LIMIT_W-1:0]         s_r;
  logic [COORD_W-1:0]         ix_r, iz_r;
  logic [15:0]                tx_r, tz_r;
  logic [1:0]                 k_r;
  logic [32:0]                w_r;
  logic signed [ACC_W-1:0]    acc_r, y_val;
  logic signed [MUL_AW-1:0]   mul_a;
  logic signed [MUL_BW-1:0]   mul_b;
  logic signed [MUL_PW-1:0]   prod_r;
  logic [16:0]                wx, wz;
  store_req_t                 sreq;
  logic                       accept, low_sun, off_map, at_edge, hit, climbed;
  logic                       res_v, res_bit, out_valid_r, out_shadowed_r;
  logic signed [21:0]         sun_y20;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE) || div_busy;
  assign cfg_ready = !div_busy;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign dim_eff   = (dim_r == 8'd0) ? 8'd1 : dim_r;

  // sun_y * 20 below 16384 means the sun sits under 0.05
  assign sun_y20 = (22'(sun_y_r) <<< 4) + (22'(sun_y_r) <<< 2);
  assign low_sun = sun_y20 < 22'sd16384;
  assign off_map = gx_r[9] || gz_r[9] ||
                   (gx_r > $signed({2'b00, dim_eff})) || (gz_r > $signed({2'b00, dim_eff}));
  assign at_edge = fx_r[31] || fz_r[31] ||
                   (fx_r[31:16] >= {8'd0, dim_eff}) || (fz_r[31:16] >= {8'd0, dim_eff});

  assign wx = k_r[0] ? {1'b0, tx_r} : (17'h10000 - {1'b0, tx_r});
  assign wz = k_r[1] ? {1'b0, tz_r} : (17'h10000 - {1'b0, tz_r});

  assign y_val = (ACC_W'(h0_r + 24'sd0) + ACC_W'(START_BIAS)) <<< 32;
  assign hit     = (y_val + $signed({10'd0, rise_r, 17'd0})) < acc_r;
  assign climbed = (34'(START_BIAS * 32768) + {1'b0, rise_r}) > 34'(CLIMB_LIM);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sun_x_r <= '0;
      sun_y_r <= 16'sd16384;
      sun_z_r <= '0;
      cell_r  <= 16'd256;
      dim_r   <= 8'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SUN_X:   sun_x_r <= cfg_wdata;
        REG_SUN_Y:   sun_y_r <= cfg_wdata;
        REG_SUN_Z:   sun_z_r <= cfg_wdata;
        REG_CELL:    cell_r  <= cfg_wdata;
        REG_MAP_DIM: dim_r   <= cfg_wdata[7:0];
        default:     ;
      endcase
    end
  end

  hsm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cfg_we && (cfg_index == REG_CELL)),
    .cell_q8 (cfg_wdata),
    .busy    (div_busy),
    .limit_r (limit)
  );

  hsm_store u_store (
    .clk     (clk),
    .req     (sreq),
    .rd_data (rd_data)
  );

  hsm_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && in_cmd == CMD_QUERY) state_nxt = ST_CHK;
      ST_CHK:  state_nxt = (low_sun || off_map) ? ST_IDLE : ST_H0;
      ST_H0:   state_nxt = ST_ADV;
      ST_ADV:  state_nxt = (s_r == limit) ? ST_IDLE : ST_ADDR;
      ST_ADDR: state_nxt = at_edge ? ST_CMP : ST_CA;
      ST_CA:   state_nxt = ST_CB;
      ST_CB:   state_nxt = ST_CC;
      ST_CC:   state_nxt = ST_CD;
      ST_CD:   state_nxt = (k_r == 2'd3) ? ST_CMP : ST_CA;
      ST_CMP:  state_nxt = (hit || climbed) ? ST_IDLE : ST_ADV;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs: store port, multiplier operands, result
  always_comb begin
    sreq.we    = 1'b0;
    sreq.addr  = {in_grid_z[COORD_W-1:0], in_grid_x[COORD_W-1:0]};
    sreq.wdata = in_height;
    mul_a      = MUL_AW'(sun_y_r);
    mul_b      = {2'b00, ((cell_r < 16'(CELL_MIN)) ? 16'(CELL_MIN) : cell_r)};
    res_v      = 1'b0;
    res_bit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        sreq.we = accept && (in_cmd == CMD_WRITE) && !in_grid_x[9] && !in_grid_z[9] &&
                  (in_grid_x <= 10'sd255) && (in_grid_z <= 10'sd255);
      end
      ST_CHK: begin
        sreq.addr = {gz_r[COORD_W-1:0], gx_r[COORD_W-1:0]};
        res_v     = low_sun || off_map;
        res_bit   = low_sun;
      end
      ST_ADV: begin
        res_v = (s_r == limit);
      end
      ST_CA: begin
        sreq.addr = {iz_r + COORD_W'(k_r[1]), ix_r + COORD_W'(k_r[0])};
        mul_a     = {8'd0, wx};
        mul_b     = {1'b0, wz};
      end
      ST_CB: begin
        mul_a = MUL_AW'(rd_data);
        mul_b = {2'b00, prod_r[15:0]};
      end
      ST_CC: begin
        mul_a = MUL_AW'(h_r);
        mul_b = {1'b0, w_r[32:16]};
      end
      ST_CMP: begin
        res_v   = hit || climbed;
        res_bit = hit;
      end
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        gx_r <= in_grid_x;
        gz_r <= in_grid_z;
      end
      ST_CHK: ;
      ST_H0: begin
        h0_r   <= rd_data;
        dy_r   <= prod_r[31:0];
        rise_r <= '0;
        fx_r   <= {{6{gx_r[9]}}, gx_r, 16'd0};
        fz_r   <= {{6{gz_r[9]}}, gz_r, 16'd0};
        s_r    <= '0;
      end
      ST_ADV: begin
        s_r    <= s_r + LIMIT_W'(1);
        fx_r   <= fx_r + {{15{sun_x_r[15]}}, sun_x_r, 1'b0};
        fz_r   <= fz_r + {{15{sun_z_r[15]}}, sun_z_r, 1'b0};
        rise_r <= rise_r + {1'b0, dy_r};
      end
      ST_ADDR: begin
        ix_r  <= fx_r[16 +: COORD_W];
        iz_r  <= fz_r[16 +: COORD_W];
        tx_r  <= fx_r[15:0];
        tz_r  <= fz_r[15:0];
        k_r   <= '0;
        acc_r <= '0;
      end
      ST_CA: ;
      ST_CB: begin
        w_r <= prod_r[32:0];
        h_r <= rd_data;
      end
      ST_CC: acc_r <= acc_r + ACC_W'(prod_r);
      ST_CD: begin
        acc_r <= acc_r + {prod_r[MUL_PW-1], prod_r, 16'd0};
        k_r   <= k_r + 2'd1;
      end
      ST_CMP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_shadowed_r <= res_bit;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= res_v;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_shadowed = out_shadowed_r;
endmodule
`default_nettype wire

FILE: rtl/hsm_store.sv
// Height sample store: one write and one registered read of the same address per cycle.
`default_nettype none
module hsm_store
  import hsm_pkg::*;
(
  input  wire logic                       clk,
  input  wire store_req_t                 req,
  output logic signed [HEIGHT_W-1:0]      rd_data
);
  logic signed [HEIGHT_W-1:0] mem [2**STORE_AW];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    rd_data <= mem[req.addr];
  end
endmodule
`default_nettype wire

FILE: rtl/hsm_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module hsm_mul
  import hsm_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic signed [MUL_AW-1:0] a,
  input  wire logic signed [MUL_BW-1:0] b,
  output logic signed [MUL_PW-1:0]      prod_r
);
  always_ff @(posedge clk) begin
    prod_r <= MUL_PW'(a) * MUL_PW'(b);
  end
endmodule
`default_nettype wire

FILE: rtl/hsm_div.sv
// Bit-serial divider computing the march step limit from the cell size.
`default_nettype none
module hsm_div
  import hsm_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [15:0]        cell_q8,
  output logic                    busy,
  output logic [LIMIT_W-1:0]      limit_r
);
  logic [DIV_W-1:0]   quo_r, quo_nxt;
  logic [15:0]        rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic [LIMIT_W-1:0] limit_nxt;
  logic [16:0]        trial, diff;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    limit_nxt = limit_r;
    if (start) begin
      quo_nxt  = DIV_W'(LIMIT_NUM);
      rem_nxt  = '0;
      dvs_nxt  = (cell_q8 < 16'(CELL_MIN)) ? 16'(CELL_MIN) : cell_q8;
      cnt_nxt  = 5'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[16]) begin
        rem_nxt = diff[15:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt  = 1'b0;
        limit_nxt = quo_nxt[LIMIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r  <= 1'b0;
      limit_r <= LIMIT_W'(LIMIT_RST);
    end else begin
      busy_r  <= busy_nxt;
      limit_r <= limit_nxt;
    end
  end

  assign busy = busy_r;
endmodule
`default_nettype wire

FILE: rtl/hsm_chk.sv
// Port-level checker for the heightfield shadow march block, with its bind.
`default_nettype none
module hsm_chk
  import hsm_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_cmd,
  input wire logic out_valid
);
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_WRITE) |=> !out_valid)
    else $error("write transfer produced a result");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == CMD_QUERY) |=> busy)
    else $error("query transfer did not raise busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid)) else $error("not idle after reset");
endmodule

bind heightfield_shadow_march hsm_chk u_hsm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid)
);
`default_nettype wire

FILE: verif/heightfield_shadow_march_tb.sv
// Testbench for heightfield_shadow_march: preload, directed and random queries checked.
`default_nettype none
module heightfield_shadow_march_tb;
  import hsm_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int SIDE = MAX_DIM + 1;
  localparam int PRE_SIDE = 16;   // marching maps stay inside this preloaded corner

  // Shadow predictor plus queue of expected shadow bits.
  class shadow_scoreboard;
    int          heights[SIDE*SIDE];
    longint      sun_x, sun_y, sun_z;
    int unsigned cell_q8, dim_reg, step_cap;
    bit          shadow_q[$];
    int          errors;

    function new();
      sun_x = 0; sun_y = 16384; sun_z = 0;
      cell_q8 = 256; dim_reg = 255; step_cap = LIMIT_RST;
      errors = 0;
    endfunction

    function int unsigned cell_eff();
      return (cell_q8 < CELL_MIN) ? CELL_MIN : cell_q8;
    endfunction

    function int unsigned dim_eff();
      if (dim_reg < 1) return 1;
      if (dim_reg > MAX_DIM) return MAX_DIM;
      return dim_reg;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        REG_SUN_X: sun_x = longint'($signed(d));
        REG_SUN_Y: sun_y = longint'($signed(d));
        REG_SUN_Z: sun_z = longint'($signed(d));
        REG_CELL: begin
          cell_q8 = d;
          step_cap = LIMIT_NUM / cell_eff();
        end
        REG_MAP_DIM: dim_reg = d[7:0];
        default: ;
      endcase
    endfunction

    function longint height_at(longint x, longint z);
      return longint'(heights[z*SIDE + x]);
    endfunction

    // bilinear terrain height, 2^-40 m units
    function longint bilerp(longint fx, longint fz, int unsigned dim);
      longint ix, iz, tx, tz, a, b;
      if (fx < 0 || fz < 0) return 0;
      ix = fx >>> 16; iz = fz >>> 16;
      if (ix >= dim || iz >= dim) return 0;
      tx = fx & 65535; tz = fz & 65535;
      a = height_at(ix, iz) * (65536 - tx) + height_at(ix + 1, iz) * tx;
      b = height_at(ix, iz + 1) * (65536 - tx) + height_at(ix + 1, iz + 1) * tx;
      return a * (65536 - tz) + b * tz;
    endfunction

    function bit march(longint gx, longint gz);
      int unsigned dim;
      longint h0, fx, fz, rise, ray_y;
      dim = dim_eff();
      if (sun_y * 20 < 16384) return 1'b1;
      if (gx < 0 || gz < 0 || gx > dim || gz > dim) return 1'b0;
      h0 = height_at(gx, gz);
      for (longint s = 1; s <= step_cap; s++) begin
        fx = gx * 65536 + 2 * sun_x * s;
        fz = gz * 65536 + 2 * sun_z * s;
        rise = sun_y * longint'(cell_eff()) * s;
        ray_y = (h0 + START_BIAS) * 64'sd4294967296 + rise * 131072;
        if (ray_y < bilerp(fx, fz, dim)) return 1'b1;
        if (longint'(START_BIAS) * 32768 + rise > longint'(CLIMB_LIM)) break;
      end
      return 1'b0;
    endfunction

    function void note_item(logic cmd, logic signed [9:0] gx, logic signed [9:0] gz,
                            logic signed [23:0] h);
      if (cmd == CMD_WRITE) begin
        if (gx >= 0 && gz >= 0 && gx <= MAX_DIM && gz <= MAX_DIM)
          heights[int'(gz)*SIDE + int'(gx)] = int'(h);
      end else begin
        shadow_q = {shadow_q, march(longint'(gx), longint'(gz))};
      end
    endfunction

    function void check_result(bit got);
      bit want;
      if (shadow_q.size() == 0) begin
        $display("%0t: unexpected result shadowed=%0b", $time, got);
        errors++;
        return;
      end
      want = shadow_q.pop_front();
      if (got !== want) begin
        $display("%0t: shadowed mismatch expected %0b actual %0b", $time, want, got);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_cmd = 1'b0;
  logic signed [9:0]  in_grid_x = '0;
  logic signed [9:0]  in_grid_z = '0;
  logic signed [23:0] in_height = '0;
  logic               out_valid;
  logic               out_shadowed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_wdata = '0;

  shadow_scoreboard sb = new();

  heightfield_shadow_march dut (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_grid_x, .in_grid_z, .in_height,
    .out_valid, .out_shadowed, .cfg_valid, .cfg_ready, .cfg_index, .cfg_wdata
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_shadowed);
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // start stays high across back-to-back transfers
  task automatic send(logic cmd, int gx, int gz, int h, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    in_cmd    <= cmd;
    in_grid_x <= gx[9:0];
    in_grid_z <= gz[9:0];
    in_height <= h[23:0];
    do @(posedge clk); while (busy);
    sb.note_item(cmd, gx[9:0], gz[9:0], h[23:0]);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.shadow_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, int d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d[15:0];
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d[15:0]);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sun(int x, int y, int z, int spacing, int dim);
    wait_idle();
    reg_write(REG_SUN_X, x);
    reg_write(REG_SUN_Y, y);
    reg_write(REG_SUN_Z, z);
    reg_write(REG_CELL, spacing);
    reg_write(REG_MAP_DIM, dim);
  endtask

  function automatic int terrain_height();
    if ($urandom_range(0, 19) == 0) return int'($urandom());
    return int'($urandom_range(0, 32767)) - 16384;
  endfunction

  task automatic random_items(int n);
    int dim, gx, gz;
    dim = int'(sb.dim_eff());
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 9) == 0) begin
          gx = int'($urandom_range(0, 1023)) - 512;
          gz = int'($urandom_range(0, 1023)) - 512;
        end else begin
          gx = $urandom_range(0, dim);
          gz = $urandom_range(0, dim);
        end
        send(CMD_WRITE, gx, gz, terrain_height(), pick_gap());
      end else begin
        if ($urandom_range(0, 4) == 0) begin
          gx = int'($urandom_range(0, 1023)) - 512;
          gz = int'($urandom_range(0, 1023)) - 512;
        end else begin
          gx = int'($urandom_range(0, dim + 2)) - 1;
          gz = int'($urandom_range(0, dim + 2)) - 1;
        end
        send(CMD_QUERY, gx, gz, int'($urandom()), pick_gap());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // preload the corner that marching queries can read
    for (int z = 0; z < PRE_SIDE; z++)
      for (int x = 0; x < PRE_SIDE; x++)
        send(CMD_WRITE, x, z, terrain_height(),
             ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : 0);

    // directed, reset settings: vertical sun
    send(CMD_WRITE, 0, 0, 8388607, 0);
    send(CMD_WRITE, 255, 255, -8388608, 0);
    send(CMD_WRITE, 254, 255, -8388608, 1);
    send(CMD_WRITE, 128, 255, 2560, 0);
    send(CMD_WRITE, -1, 5, 1000, 0);
    send(CMD_WRITE, 511, 511, 1000, 2);
    send(CMD_WRITE, -512, -512, 1000, 0);
    send(CMD_WRITE, 256, 3, -1, 0);
    send(CMD_QUERY, 0, 0, 0, 0);
    send(CMD_QUERY, 255, 255, 0, 5);
    send(CMD_QUERY, 254, 255, 0, 0);
    send(CMD_QUERY, 1, 0, 0, 0);
    send(CMD_QUERY, -1, 0, 0, 3);
    send(CMD_QUERY, 0, -512, 0, 0);
    send(CMD_QUERY, 511, 511, 0, 0);
    send(CMD_QUERY, 256, 10, 0, 0);
    send(CMD_QUERY, 128, 255, -1, 20);
    wait_idle();
    reg_write(REG_UNUSED, 16'hFFFF);

    set_sun(5000, 12000, -3000, 2048, 12);
    random_items(150);
    set_sun(-16384, 16384, 16384, 65535, 15);
    random_items(120);
    set_sun(0, 819, 0, 1024, 255);           // just under the low-sun threshold
    random_items(40);
    set_sun(16384, 820, -16384, 4096, 1);    // just over it, smallest map
    random_items(100);
    set_sun(-16384, -16384, 7000, 3000, 0);  // map size zero saturates to one
    random_items(40);
    set_sun(200, 16384, 200, 10, 8);         // cell size under minimum
    send(CMD_QUERY, 3, 4, 0, 0);
    send(CMD_QUERY, 8, 8, 0, 2);
    set_sun(-300, 16384, 150, 16, 8);
    send(CMD_QUERY, 5, 2, 0, 0);
    set_sun(3000, 16384, 8000, 256, 15);
    random_items(60);

    wait_idle();
    repeat (50) @(posedge clk);
    if (sb.errors == 0)
      $display("heightfield_shadow_march_tb: PASS");
    else
      $display("heightfield_shadow_march_tb: FAIL");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("heightfield_shadow_march_tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire
